[rtl/core/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

  // Result kinds as they leave on the output tuser.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Up to four results that one input item causes. Every entry before
  // last_idx is a content byte; the entry at last_idx carries fin_kind.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    kind_e           fin_kind;
    logic [1:0]      last_idx;
  } pkt_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage : jsu_pkg

`default_nettype wire

[rtl/core/jsu_front.sv]
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       text_end_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output pkt_t            pkt_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX1    = 3'd3,
    PH_HIGH    = 3'd4,
    PH_HIGH_BS = 3'd5,
    PH_HEX2    = 3'd6
  } phase_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    unique case (c)
      8'h22:   r.val = 8'h22;
      8'h5C:   r.val = 8'h5C;
      8'h2F:   r.val = 8'h2F;
      8'h62:   r.val = 8'h08;
      8'h66:   r.val = 8'h0C;
      8'h6E:   r.val = 8'h0A;
      8'h72:   r.val = 8'h0D;
      8'h74:   r.val = 8'h09;
      default: begin
        r.ok  = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic pkt_t utf8_encode(input logic [20:0] code);
    pkt_t r;
    r = '0;
    r.fin_kind = KIND_DATA;
    if (code < 21'h80) begin
      r.bytes[0] = code[7:0];
      r.last_idx = 2'd0;
    end else if (code < 21'h800) begin
      r.bytes[0] = {3'b110, code[10:6]};
      r.bytes[1] = {2'b10, code[5:0]};
      r.last_idx = 2'd1;
    end else if (code < 21'h10000) begin
      r.bytes[0] = {4'b1110, code[15:12]};
      r.bytes[1] = {2'b10, code[11:6]};
      r.bytes[2] = {2'b10, code[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, code[20:18]};
      r.bytes[1] = {2'b10, code[17:12]};
      r.bytes[2] = {2'b10, code[11:6]};
      r.bytes[3] = {2'b10, code[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] high_q, high_d;

  logic        accept;
  hex_t        hx;
  esc_t        es;
  logic [15:0] acc_next;
  logic [20:0] joined;
  pkt_t        high_pkt;
  pkt_t        err_pkt;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hx         = hex_decode(data_byte_i);
  assign es         = esc_decode(data_byte_i);
  assign acc_next   = {acc_q[11:0], hx.val};
  assign joined     = 21'h10000 + {1'b0, high_q[9:0], acc_next[9:0]};
  assign high_pkt   = utf8_encode({5'd0, high_q});

  always_comb begin
    err_pkt          = '0;
    err_pkt.fin_kind = KIND_ERROR;
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    push_o  = 1'b0;
    pkt_o   = '0;
    if (accept) begin
      if (text_end_i) begin
        push_o  = 1'b1;
        pkt_o   = err_pkt;
        phase_d = PH_IDLE;
        acc_d   = '0;
        cnt_d   = '0;
        high_d  = '0;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (data_byte_i == CH_QUOTE) begin
              phase_d = PH_BODY;
            end else begin
              push_o = 1'b1;
              pkt_o  = err_pkt;
            end
          end
          PH_BODY: begin
            if (data_byte_i == CH_QUOTE) begin
              push_o         = 1'b1;
              pkt_o.fin_kind = KIND_CLOSE;
              phase_d        = PH_IDLE;
              acc_d          = '0;
              cnt_d          = '0;
              high_d         = '0;
            end else if (data_byte_i == CH_BSLASH) begin
              phase_d = PH_ESC;
            end else begin
              push_o         = 1'b1;
              pkt_o.bytes[0] = data_byte_i;
              pkt_o.fin_kind = KIND_DATA;
            end
          end
          PH_ESC: begin
            if (data_byte_i == CH_U) begin
              phase_d = PH_HEX1;
              acc_d   = '0;
              cnt_d   = '0;
            end else if (es.ok) begin
              push_o         = 1'b1;
              pkt_o.bytes[0] = es.val;
              pkt_o.fin_kind = KIND_DATA;
              phase_d        = PH_BODY;
            end else begin
              push_o  = 1'b1;
              pkt_o   = err_pkt;
              phase_d = PH_IDLE;
              acc_d   = '0;
              cnt_d   = '0;
              high_d  = '0;
            end
          end
          PH_HEX1, PH_HEX2: begin
            if (!hx.ok) begin
              push_o  = 1'b1;
              pkt_o   = err_pkt;
              phase_d = PH_IDLE;
              acc_d   = '0;
              cnt_d   = '0;
              high_d  = '0;
            end else if (cnt_q != 2'd3) begin
              acc_d = acc_next;
              cnt_d = cnt_q + 2'd1;
            end else begin
              acc_d = '0;
              cnt_d = '0;
              if (phase_q == PH_HEX1) begin
                if (acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
                  high_d  = acc_next;
                  phase_d = PH_HIGH;
                end else begin
                  push_o  = 1'b1;
                  pkt_o   = utf8_encode({5'd0, acc_next});
                  phase_d = PH_BODY;
                end
              end else begin
                push_o  = 1'b1;
                // A second code that is no low surrogate is dropped.
                if (acc_next >= 16'hDC00 && acc_next <= 16'hDFFF) begin
                  pkt_o = utf8_encode(joined);
                end else begin
                  pkt_o = high_pkt;
                end
                high_d  = '0;
                phase_d = PH_BODY;
              end
            end
          end
          PH_HIGH: begin
            if (data_byte_i == CH_BSLASH) begin
              phase_d = PH_HIGH_BS;
            end else begin
              // Lone high surrogate goes out first, then the byte as content, or a close if the byte is a quote.
              push_o         = 1'b1;
              pkt_o          = high_pkt;
              pkt_o.last_idx = 2'd3;
              high_d         = '0;
              if (data_byte_i == CH_QUOTE) begin
                pkt_o.fin_kind = KIND_CLOSE;
                phase_d        = PH_IDLE;
                acc_d          = '0;
                cnt_d          = '0;
              end else begin
                pkt_o.bytes[3] = data_byte_i;
                phase_d        = PH_BODY;
              end
            end
          end
          PH_HIGH_BS: begin
            if (data_byte_i == CH_U) begin
              phase_d = PH_HEX2;
              acc_d   = '0;
              cnt_d   = '0;
            end else begin
              push_o         = 1'b1;
              pkt_o          = high_pkt;
              pkt_o.last_idx = 2'd3;
              high_d         = '0;
              if (es.ok) begin
                pkt_o.bytes[3] = es.val;
                phase_d        = PH_BODY;
              end else begin
                pkt_o.fin_kind = KIND_ERROR;
                phase_d        = PH_IDLE;
                acc_d          = '0;
                cnt_d          = '0;
              end
            end
          end
          default: begin
            push_o  = 1'b1;
            pkt_o   = err_pkt;
            phase_d = PH_IDLE;
            acc_d   = '0;
            cnt_d   = '0;
            high_d  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      high_q  <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      high_q  <= high_d;
    end
  end

endmodule : jsu_front

`default_nettype wire

[rtl/core/jsu_queue.sv]
`default_nettype none

module jsu_queue
  import jsu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire pkt_t pkt_i,
  input  wire logic pop_i,
  output pkt_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  pkt_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule : jsu_queue

`default_nettype wire

[rtl/core/jsu_back.sv]
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pkt_t       head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic            out_last_o
);

  logic [1:0] idx_q;
  logic       at_end;

  assign at_end      = (idx_q == head_i.last_idx);
  assign out_valid_o = !empty_i;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign out_kind_o  = at_end ? head_i.fin_kind : KIND_DATA;
  assign out_last_o  = at_end;
  assign pop_o       = out_valid_o && out_ready_i && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule : jsu_back

`default_nettype wire

[rtl/core/json_string_unescape_utf8_core.sv]
// JSON string unescaper with UTF-8 output. Feed the raw bytes of a quoted JSON
// string one item at a time on the slave stream; the first byte must be a
// double quote. Plain bytes pass through, the eight simple backslash escapes
// are decoded, and \uXXXX escapes are decoded, with a high surrogate joined
// to a directly following \u low surrogate into one supplementary code point.
// Each code point leaves as one to four UTF-8 bytes on the master stream,
// tuser telling content (0), string closed (1) or error (2), and tlast marking
// the final result caused by one input item. An item with tlast set marks the
// end of text and always yields an error. After a close or an error the block
// waits for a new opening quote. Rate: one input item is taken per cycle as
// long as the four-entry queue between the classifier and the output
// serializer has room; results leave at one per cycle while the master
// stream is ready, so an item of N bytes holds the serializer until all N
// are out. With nothing queued ahead of it, an item's first result appears
// the cycle after the item is accepted, else behind the results queued ahead.

`default_nettype none

module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,  // text_end
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0]      m_axis_tuser_o,  // [1:0] kind
  output logic            m_axis_tlast_o   // last
);

  logic push, pop, q_full, q_empty;
  pkt_t pkt_in, head;

  // Front: tracks the string state and turns each item into at most one packet.
  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .data_byte_i (s_axis_tdata_i),
    .text_end_i  (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .pkt_o       (pkt_in)
  );

  // Packet queue decoupling classification from serialization.
  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (pkt_in),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: sends the packet entries out one result per cycle while the output is ready.
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // A close or error is always the final result of its item.
  a_ctrl_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != KIND_DATA) |-> m_axis_tlast_o)
    else $error("close or error result not marked last");

  // Close and error results carry a zero byte.
  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != KIND_DATA) |-> (m_axis_tdata_o == 8'h00))
    else $error("close or error result carries a nonzero byte");

  // The front never produces a packet into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("packet pushed into full queue");

  // A packet that arrives in an empty queue is visible on the next cycle.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_empty) |=> m_axis_tvalid_o)
    else $error("queued packet not presented on output");
`endif

endmodule : json_string_unescape_utf8_core

`default_nettype wire
